// ===== src/etdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package etdc_pkg;

  // Default graph size; the top level hands it down as MAX_NODES.
  localparam int MAX_NODES_DEF = 64;

  // Operation codes.
  localparam logic [2:0] MODE_INSERT    = 3'd0;
  localparam logic [2:0] MODE_REMOVE    = 3'd1;
  localparam logic [2:0] MODE_SET_DELTA = 3'd2;
  localparam logic [2:0] MODE_SET_COST  = 3'd3;
  localparam logic [2:0] MODE_SET_CLASS = 3'd4;
  localparam logic [2:0] MODE_READ_EDGE = 3'd5;
  localparam logic [2:0] MODE_READ_NODE = 3'd6;
  localparam logic [2:0] MODE_NOP       = 3'd7;

  // Constraint classes.
  localparam logic [1:0] CLS_FREE      = 2'd0;
  localparam logic [1:0] CLS_FORCED    = 2'd1;
  localparam logic [1:0] CLS_FORBIDDEN = 2'd2;
  localparam logic [1:0] CLS_UNUSED    = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_NODE  = 2'd1;
  localparam logic [1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [1:0] STAT_ABSENT    = 2'd3;

  // Configuration register indexes.
  localparam logic REG_NODE_COUNT = 1'b0;

  // One command word.
  typedef struct packed {
    logic [2:0]         mode;
    logic [6:0]         node_u;
    logic [6:0]         node_v;
    logic signed [31:0] cost_in;
    logic [1:0]         constraint_in;
    logic signed [31:0] delta_in;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [1:0]         status;
    logic               adjacent;
    logic signed [31:0] cost_out;
    logic [1:0]         constraint_out;
    logic signed [31:0] delta_out;
    logic [5:0]         degree_all;
    logic [5:0]         degree_forced;
    logic [5:0]         degree_forbidden;
  } result_t;

  // One slot of the edge memory.
  typedef struct packed {
    logic        present;
    logic [1:0]  cls;
    logic [31:0] cost;
    logic [31:0] delta;
  } edge_entry_t;

  // The three counters of one node.
  typedef struct packed {
    logic [5:0] all_cnt;
    logic [5:0] forced_cnt;
    logic [5:0] forbidden_cnt;
  } node_cnt_t;

  // Memory strobes from the sequencer.
  typedef struct packed {
    logic rd;
    logic edge_wr;
    logic node_wr;
  } mem_ctl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_WRITE_V
  } state_t;

endpackage

`default_nettype wire

// ===== src/etdc_edge_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etdc_edge_mem import etdc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int EDGE_SLOTS = MAX_NODES * (MAX_NODES - 1) / 2,
  localparam int SLOT_W = $clog2(EDGE_SLOTS)
) (
  input  wire logic              clk,
  input  wire mem_ctl_t          ctl,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output      edge_entry_t       rd_data,
  input  wire logic [SLOT_W-1:0] wr_addr,
  input  wire edge_entry_t       wr_data
);

  edge_entry_t mem [EDGE_SLOTS];

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (ctl.edge_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/etdc_node_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etdc_node_mem import etdc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int NODE_W = $clog2(MAX_NODES)
) (
  input  wire logic              clk,
  input  wire mem_ctl_t          ctl,
  input  wire logic [NODE_W-1:0] rd_addr_a,
  input  wire logic [NODE_W-1:0] rd_addr_b,
  output      node_cnt_t         rd_data_a,
  output      node_cnt_t         rd_data_b,
  input  wire logic [NODE_W-1:0] wr_addr,
  input  wire node_cnt_t         wr_data
);

  // Two identical copies give two read ports; every write goes to both.
  node_cnt_t copy_a [MAX_NODES];
  node_cnt_t copy_b [MAX_NODES];

  always_ff @(posedge clk) begin
    if (ctl.node_wr) begin
      copy_a[wr_addr] <= wr_data;
      copy_b[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data_a <= copy_a[rd_addr_a];
      rd_data_b <= copy_b[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ===== src/etdc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etdc_ctrl import etdc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int EDGE_SLOTS = MAX_NODES * (MAX_NODES - 1) / 2,
  localparam int SLOT_W = $clog2(EDGE_SLOTS),
  localparam int NODE_W = $clog2(MAX_NODES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [6:0]        node_count,
  input  wire logic              start,
  output      logic              busy,
  input  wire item_t             req,
  output      logic              done,
  output      result_t           rsp,
  output      mem_ctl_t          ctl,
  output      logic [SLOT_W-1:0] edge_rd_addr,
  output      logic [SLOT_W-1:0] edge_wr_addr,
  output      edge_entry_t       edge_wr_data,
  input  wire edge_entry_t       edge_rd_data,
  output      logic [NODE_W-1:0] node_rd_addr_a,
  output      logic [NODE_W-1:0] node_rd_addr_b,
  output      logic [NODE_W-1:0] node_wr_addr,
  output      node_cnt_t         node_wr_data,
  input  wire node_cnt_t         node_rd_data_a,
  input  wire node_cnt_t         node_rd_data_b
);

  // Node numbers are seven bits wide, so no more than 127 can ever be live.
  localparam int LIMIT = (MAX_NODES > 127) ? 127 : MAX_NODES;

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] sweep;
  item_t             item;
  node_cnt_t         cnt_v_hold;

  logic [6:0]        n_act;
  logic [6:0]        hi;
  logic [6:0]        lo;
  logic [13:0]       tri_prod;
  logic [13:0]       slot_full;
  logic              u_ok;
  logic              v_ok;
  logic              pair_ok;
  logic [SLOT_W-1:0] slot;
  logic [NODE_W-1:0] ui;
  logic [NODE_W-1:0] vi;
  logic [1:0]        cls_in;

  edge_entry_t       e_new;
  node_cnt_t         cu_new;
  node_cnt_t         cv_new;
  logic              upd_edge_wr;
  logic              upd_node_wr;
  result_t           res;

  // Moves the class counter of one node up or down by one, modulo 64.
  function automatic node_cnt_t cls_step(node_cnt_t c, logic [1:0] k, logic up);
    node_cnt_t  r;
    logic [5:0] d;
    r = c;
    d = up ? 6'd1 : 6'd63;
    if (k == CLS_FORCED) begin
      r.forced_cnt = r.forced_cnt + d;
    end else if (k == CLS_FORBIDDEN) begin
      r.forbidden_cnt = r.forbidden_cnt + d;
    end
    return r;
  endfunction

  // Node number checks and the triangular slot of the pair.
  always_comb begin
    n_act     = (node_count > 7'(LIMIT)) ? 7'(LIMIT) : node_count;
    u_ok      = (item.node_u != 7'd0) && (item.node_u <= n_act);
    v_ok      = (item.node_v != 7'd0) && (item.node_v <= n_act);
    hi        = (item.node_u > item.node_v) ? item.node_u : item.node_v;
    lo        = (item.node_u > item.node_v) ? item.node_v : item.node_u;
    tri_prod  = {7'd0, hi} * {7'd0, hi - 7'd1};
    slot_full = (tri_prod >> 1) + {7'd0, lo} - 14'd1;
    slot      = SLOT_W'(slot_full);
    // A pair whose slot lies past the end of the triangle is refused.
    pair_ok   = u_ok && v_ok && (item.node_u != item.node_v) &&
                (32'(slot_full) < 32'(EDGE_SLOTS));
    ui        = NODE_W'(item.node_u - 7'd1);
    vi        = NODE_W'(item.node_v - 7'd1);
    cls_in    = (item.constraint_in == CLS_UNUSED) ? CLS_FREE : item.constraint_in;
  end

  // Read-modify step: new slot contents, new counters and the result word.
  always_comb begin
    res         = '0;
    e_new       = edge_rd_data;
    cu_new      = node_rd_data_a;
    cv_new      = node_rd_data_b;
    upd_edge_wr = 1'b0;
    upd_node_wr = 1'b0;
    case (item.mode)
      MODE_NOP: begin
        res.status = STAT_OK;
      end
      MODE_READ_NODE: begin
        if (!u_ok) begin
          res.status = STAT_BAD_NODE;
        end else begin
          res.degree_all       = node_rd_data_a.all_cnt;
          res.degree_forced    = node_rd_data_a.forced_cnt;
          res.degree_forbidden = node_rd_data_a.forbidden_cnt;
        end
      end
      default: begin
        if (!pair_ok) begin
          res.status = STAT_BAD_NODE;
        end else if ((item.mode == MODE_INSERT) && edge_rd_data.present) begin
          res.status         = STAT_DUPLICATE;
          res.adjacent       = edge_rd_data.present;
          res.cost_out       = edge_rd_data.cost;
          res.constraint_out = edge_rd_data.cls;
          res.delta_out      = edge_rd_data.delta;
        end else if ((item.mode != MODE_INSERT) && !edge_rd_data.present) begin
          res.status = STAT_ABSENT;
        end else begin
          case (item.mode)
            MODE_INSERT: begin
              e_new.present  = 1'b1;
              e_new.cls      = cls_in;
              e_new.cost     = item.cost_in;
              e_new.delta    = '0;
              cu_new.all_cnt = node_rd_data_a.all_cnt + 6'd1;
              cv_new.all_cnt = node_rd_data_b.all_cnt + 6'd1;
              cu_new         = cls_step(cu_new, cls_in, 1'b1);
              cv_new         = cls_step(cv_new, cls_in, 1'b1);
              upd_edge_wr    = 1'b1;
              upd_node_wr    = 1'b1;
            end
            MODE_REMOVE: begin
              cu_new.all_cnt = node_rd_data_a.all_cnt - 6'd1;
              cv_new.all_cnt = node_rd_data_b.all_cnt - 6'd1;
              cu_new         = cls_step(cu_new, edge_rd_data.cls, 1'b0);
              cv_new         = cls_step(cv_new, edge_rd_data.cls, 1'b0);
              e_new          = '0;
              upd_edge_wr    = 1'b1;
              upd_node_wr    = 1'b1;
            end
            MODE_SET_DELTA: begin
              e_new.delta = item.delta_in;
              upd_edge_wr = 1'b1;
            end
            MODE_SET_COST: begin
              e_new.cost  = item.cost_in;
              upd_edge_wr = 1'b1;
            end
            MODE_SET_CLASS: begin
              cu_new      = cls_step(cu_new, edge_rd_data.cls, 1'b0);
              cv_new      = cls_step(cv_new, edge_rd_data.cls, 1'b0);
              cu_new      = cls_step(cu_new, cls_in, 1'b1);
              cv_new      = cls_step(cv_new, cls_in, 1'b1);
              e_new.cls   = cls_in;
              upd_edge_wr = 1'b1;
              upd_node_wr = 1'b1;
            end
            default: begin
              e_new = edge_rd_data;
            end
          endcase
          res.status         = STAT_OK;
          res.adjacent       = e_new.present;
          res.cost_out       = e_new.cost;
          res.constraint_out = e_new.cls;
          res.delta_out      = e_new.delta;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep == SLOT_W'(EDGE_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = upd_node_wr ? ST_WRITE_V : ST_IDLE;
      end
      ST_WRITE_V: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Memory strobes and addresses for each state.
  always_comb begin
    ctl            = '0;
    edge_rd_addr   = slot;
    edge_wr_addr   = slot;
    edge_wr_data   = e_new;
    node_rd_addr_a = ui;
    node_rd_addr_b = vi;
    node_wr_addr   = ui;
    node_wr_data   = cu_new;
    busy           = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        ctl.edge_wr  = 1'b1;
        ctl.node_wr  = (sweep < SLOT_W'(MAX_NODES));
        edge_wr_addr = sweep;
        edge_wr_data = '0;
        node_wr_addr = NODE_W'(sweep);
        node_wr_data = '0;
      end
      ST_READ: begin
        ctl.rd = 1'b1;
      end
      ST_UPDATE: begin
        ctl.edge_wr = upd_edge_wr;
        ctl.node_wr = upd_node_wr;
      end
      ST_WRITE_V: begin
        ctl.node_wr  = 1'b1;
        node_wr_addr = vi;
        node_wr_data = cnt_v_hold;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPDATE);
      if (state == ST_CLEAR) begin
        sweep <= sweep + 1'b1;
      end
    end
  end

  // Command, result and second-node counter holding registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      item <= req;
    end
    if (state == ST_UPDATE) begin
      rsp        <= res;
      cnt_v_hold <= cv_new;
    end
  end

  // A result word only follows the update step.
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result strobe without an update step");

  // Memories are never written while the block waits for a command.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!ctl.edge_wr && !ctl.node_wr))
    else $error("memory write while idle");

  // An accepted command starts with the read step.
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_READ))
    else $error("accepted command did not start a read");

  // The second counter write only follows an update that wrote counters.
  a_write_v_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE_V) |-> $past(state == ST_UPDATE && ctl.node_wr))
    else $error("second node write out of order");

endmodule

`default_nettype wire

// ===== src/edge_table_with_degree_counts_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Undirected edge table with per-node degree counters.
// Commands: a word on req is taken at a rising edge where start is high and
// busy is low. Each command gives exactly one result word on rsp, marked by
// done for a single cycle; the receiver cannot stall it, so it must take it.
// Each command passes a read step, where the edge slot and both node
// counters are read in one cycle, and then an update step, which makes any
// writes to the edge slot and the first node's counters in the next; done
// and the rsp word are registered from the update step. A successful insert,
// remove or set constraint then writes the second node's counters through
// the single write port of the node counter memory in a further write step.
// Configuration: an APB register node_count at byte address 0. The user must
// write it only while busy is low and no result is pending; the block itself
// does not enforce this. Reset: rst clears node_count and starts a clearing
// pass that zeroes all MAX_NODES*(MAX_NODES-1)/2 slots (2016 for 64 nodes)
// of the edge memory one slot per cycle, with the node counters alongside.
// busy stays high throughout; configuration writes are still taken.

module edge_table_with_degree_counts_unit import etdc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        start,
  output      logic        busy,
  input  wire item_t       req,
  output      logic        done,
  output      result_t     rsp
);

  localparam int EDGE_SLOTS = MAX_NODES * (MAX_NODES - 1) / 2;
  localparam int SLOT_W = $clog2(EDGE_SLOTS);
  localparam int NODE_W = $clog2(MAX_NODES);

  logic [6:0]        node_count;
  mem_ctl_t          ctl;
  logic [SLOT_W-1:0] edge_rd_addr;
  logic [SLOT_W-1:0] edge_wr_addr;
  edge_entry_t       edge_wr_data;
  edge_entry_t       edge_rd_data;
  logic [NODE_W-1:0] node_rd_addr_a;
  logic [NODE_W-1:0] node_rd_addr_b;
  logic [NODE_W-1:0] node_wr_addr;
  node_cnt_t         node_wr_data;
  node_cnt_t         node_rd_data_a;
  node_cnt_t         node_rd_data_b;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT)) begin
      node_count <= pwdata[6:0];
    end
  end

  // Configuration read-back.
  always_comb begin
    pready = 1'b1;
    prdata = (paddr[2] == REG_NODE_COUNT) ? {25'd0, node_count} : 32'd0;
  end

  etdc_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .node_count     (node_count),
    .start          (start),
    .busy           (busy),
    .req            (req),
    .done           (done),
    .rsp            (rsp),
    .ctl            (ctl),
    .edge_rd_addr   (edge_rd_addr),
    .edge_wr_addr   (edge_wr_addr),
    .edge_wr_data   (edge_wr_data),
    .edge_rd_data   (edge_rd_data),
    .node_rd_addr_a (node_rd_addr_a),
    .node_rd_addr_b (node_rd_addr_b),
    .node_wr_addr   (node_wr_addr),
    .node_wr_data   (node_wr_data),
    .node_rd_data_a (node_rd_data_a),
    .node_rd_data_b (node_rd_data_b)
  );

  etdc_edge_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_edge_mem (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (edge_rd_addr),
    .rd_data (edge_rd_data),
    .wr_addr (edge_wr_addr),
    .wr_data (edge_wr_data)
  );

  etdc_node_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_node_mem (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr_a (node_rd_addr_a),
    .rd_addr_b (node_rd_addr_b),
    .rd_data_a (node_rd_data_a),
    .rd_data_b (node_rd_data_b),
    .wr_addr   (node_wr_addr),
    .wr_data   (node_wr_data)
  );

endmodule

`default_nettype wire
